// ----- rtl/core/cfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    localparam int FIELD_W = 14;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd2;

    localparam logic [FIELD_W-1:0] LOOP_EXT = 14'd9999;

    typedef struct packed {
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] to;
    } t_rule;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_RULE,
        ST_SCAN_VIS,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic add;
        logic load;
        logic scan_rst;
        logic rule_step;
        logic vis_step;
        logic take_next;
        logic push;
        logic mark_loop;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic rule_hit;
        logic rule_done;
        logic seen_hit;
        logic vis_done;
        logic vis_full;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/core/cfr_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cfr_in_if;
    logic                        valid;
    logic                        ready;
    logic [cfr_pkg::CMD_W-1:0]   cmd;
    logic [cfr_pkg::FIELD_W-1:0] ext;
    logic [cfr_pkg::FIELD_W-1:0] when;
    logic [cfr_pkg::FIELD_W-1:0] span;
    logic [cfr_pkg::FIELD_W-1:0] dest;

    modport source (output valid, cmd, ext, when, span, dest, input ready);
    modport sink   (input valid, cmd, ext, when, span, dest, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cfr_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cfr_out_if;
    logic                        valid;
    logic                        ready;
    logic [cfr_pkg::FIELD_W-1:0] final_ext;
    logic                        loop_found;

    modport source (output valid, final_ext, loop_found, input ready);
    modport sink   (input valid, final_ext, loop_found, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cfr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfr_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [cfr_pkg::CMD_W-1:0] i_in_cmd,
    input  cfr_pkg::t_dp_sts          i_sts,
    output logic                      o_in_ready,
    output cfr_pkg::t_dp_cmd          o_cmd
);

    cfr_pkg::t_state r_state;
    cfr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfr_pkg::ST_IDLE: begin
                if (i_in_valid && (i_in_cmd == cfr_pkg::CMD_RESOLVE)) begin
                    n_state = cfr_pkg::ST_SCAN_RULE;
                end
            end
            cfr_pkg::ST_SCAN_RULE: begin
                if (i_sts.rule_hit) begin
                    n_state = cfr_pkg::ST_SCAN_VIS;
                end else if (i_sts.rule_done) begin
                    n_state = cfr_pkg::ST_EMIT;
                end
            end
            cfr_pkg::ST_SCAN_VIS: begin
                if (i_sts.seen_hit || i_sts.vis_done) begin
                    n_state = (i_sts.seen_hit || i_sts.vis_full) ? cfr_pkg::ST_EMIT
                                                                 : cfr_pkg::ST_SCAN_RULE;
                end
            end
            cfr_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = cfr_pkg::ST_IDLE;
                end
            end
            default: n_state = cfr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            cfr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_in_cmd)
                        cfr_pkg::CMD_CLEAR: o_cmd.clear = 1'b1;
                        cfr_pkg::CMD_ADD:   o_cmd.add   = 1'b1;
                        cfr_pkg::CMD_RESOLVE: begin
                            o_cmd.load     = 1'b1;
                            o_cmd.scan_rst = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            cfr_pkg::ST_SCAN_RULE: begin
                if (i_sts.rule_hit) begin
                    o_cmd.take_next = 1'b1;
                    o_cmd.scan_rst  = 1'b1;
                end else if (!i_sts.rule_done) begin
                    o_cmd.rule_step = 1'b1;
                end
            end
            cfr_pkg::ST_SCAN_VIS: begin
                if (i_sts.seen_hit || (i_sts.vis_done && i_sts.vis_full)) begin
                    o_cmd.mark_loop = 1'b1;
                end else if (i_sts.vis_done) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.scan_rst = 1'b1;
                end else begin
                    o_cmd.vis_step = 1'b1;
                end
            end
            cfr_pkg::ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/cfr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfr_dp #(
    parameter int MAX_RULES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfr_pkg::t_dp_cmd            i_cmd,
    input  logic [cfr_pkg::FIELD_W-1:0] i_ext,
    input  logic [cfr_pkg::FIELD_W-1:0] i_when,
    input  logic [cfr_pkg::FIELD_W-1:0] i_span,
    input  logic [cfr_pkg::FIELD_W-1:0] i_dest,
    input  logic                        i_out_ready,
    output cfr_pkg::t_dp_sts            o_sts,
    output logic                        o_out_valid,
    output logic [cfr_pkg::FIELD_W-1:0] o_final_ext,
    output logic                        o_loop_found
);

    localparam int FW  = cfr_pkg::FIELD_W;
    localparam int AW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW  = $clog2(MAX_RULES + 1);
    localparam int VD  = MAX_RULES + 1;
    localparam int VAW = $clog2(VD);
    localparam int VCW = $clog2(VD + 1);

    cfr_pkg::t_rule r_rule_mem [MAX_RULES];
    logic [FW-1:0]  r_vis_mem  [VD];

    cfr_pkg::t_rule r_rule_q;
    logic [FW-1:0]  r_vis_q;
    logic [CW-1:0]  r_rule_cnt;
    logic [VCW-1:0] r_vcnt;
    logic [VCW-1:0] r_ptr;
    logic           r_rd_vld;
    logic [FW-1:0]  r_cur;
    logic [FW-1:0]  r_when;
    logic [FW-1:0]  r_next;
    logic           r_loop_pend;
    logic           r_out_vld;
    logic [FW-1:0]  r_final;
    logic           r_loop;

    logic           rule_more;
    logic           vis_more;
    logic           rule_match;
    logic [FW:0]    win_end;
    logic           vis_we;
    logic [VAW-1:0] vis_waddr;
    logic [FW-1:0]  vis_wdata;

    assign rule_more  = r_ptr < VCW'(r_rule_cnt);
    assign vis_more   = r_ptr < r_vcnt;
    assign win_end    = (FW + 1)'(r_rule_q.start) + (FW + 1)'(r_rule_q.len);
    assign rule_match = (r_rule_q.src == r_cur) && (r_when >= r_rule_q.start)
                        && ((FW + 1)'(r_when) <= win_end);

    assign vis_we    = i_cmd.load || i_cmd.push;
    assign vis_waddr = i_cmd.load ? '0 : r_vcnt[VAW-1:0];
    assign vis_wdata = i_cmd.load ? i_ext : r_next;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add && (r_rule_cnt < CW'(MAX_RULES))) begin
            r_rule_mem[r_rule_cnt[AW-1:0]] <= '{src: i_ext, start: i_when,
                                                len: i_span, to: i_dest};
        end
        r_rule_q <= r_rule_mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_vis_mem[vis_waddr] <= vis_wdata;
        end
        r_vis_q <= r_vis_mem[r_ptr[VAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_rule_cnt <= '0;
        end else if (i_cmd.add && (r_rule_cnt < CW'(MAX_RULES))) begin
            r_rule_cnt <= r_rule_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_rst) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.rule_step) begin
            r_rd_vld <= rule_more;
            if (rule_more) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end else if (i_cmd.vis_step) begin
            r_rd_vld <= vis_more;
            if (vis_more) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end else begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt      <= '0;
            r_loop_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_vcnt      <= VCW'(1);
            r_loop_pend <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_vcnt <= r_vcnt + 1'b1;
            end
            if (i_cmd.mark_loop) begin
                r_loop_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur  <= i_ext;
            r_when <= i_when;
        end else if (i_cmd.push) begin
            r_cur <= r_next;
        end
        if (i_cmd.take_next) begin
            r_next <= r_rule_q.to;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_final <= r_loop_pend ? cfr_pkg::LOOP_EXT : r_cur;
            r_loop  <= r_loop_pend;
        end
    end

    always_comb begin
        o_sts.rule_hit  = r_rd_vld && rule_match;
        o_sts.rule_done = !r_rd_vld && !rule_more;
        o_sts.seen_hit  = r_rd_vld && (r_vis_q == r_next);
        o_sts.vis_done  = !r_rd_vld && !vis_more;
        o_sts.vis_full  = r_vcnt >= VCW'(VD);
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid  = r_out_vld;
    assign o_final_ext  = r_final;
    assign o_loop_found = r_loop;

`ifndef SYNTHESIS
    a_rule_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rule_cnt <= CW'(MAX_RULES))
        else $error("rule count beyond table depth");

    a_vis_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= VCW'(VD))
        else $error("visited count beyond list depth");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_vld || i_out_ready))
        else $error("result overwrites a pending item");

    a_read_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.rule_step || i_cmd.vis_step))
        else $error("read data flagged valid without a read");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/call_forward_resolver_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload                          Handshake
// i_in     sink       cmd, ext, when, span, dest       valid / ready
// o_out    source     final_ext, loop_found            valid / ready
//
// Clear and add are handled in the idle state; an unused command is taken and dropped.
// A resolve walks the chain hop by hop; each hop scans the rule memory and, after
// a hit, the visited list, one entry a cycle through the single read port of each.
// Reset clears the rule and visited counts; no clearing pass is run.
// A result waits in the output register while the next item is taken; a resolve
// that finishes with the register still full holds until it drains.

module call_forward_resolver_unit #(
    parameter int MAX_RULES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfr_in_if.sink     i_in,
    cfr_out_if.source  o_out
);

    cfr_pkg::t_dp_cmd dp_cmd;
    cfr_pkg::t_dp_sts dp_sts;
    logic             in_ready;

    cfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_sts      (dp_sts),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    cfr_dp #(
        .MAX_RULES (MAX_RULES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_ext        (i_in.ext),
        .i_when       (i_in.when),
        .i_span       (i_in.span),
        .i_dest       (i_in.dest),
        .i_out_ready  (o_out.ready),
        .o_sts        (dp_sts),
        .o_out_valid  (o_out.valid),
        .o_final_ext  (o_out.final_ext),
        .o_loop_found (o_out.loop_found)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int FW           = cfr_pkg::FIELD_W;
    localparam int CW           = cfr_pkg::CMD_W;
    localparam int RULE_SLOTS   = 64;
    localparam int RANDOM_ITEMS = 140;
    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int TAIL_CYCLES  = 200;
    localparam int REPORT_MAX   = 10;

    localparam logic [CW-1:0] CMD_SPARE = 2'd3;
    localparam logic [FW-1:0] EXT_TOP   = '1;

    typedef struct packed {
        logic [FW-1:0] final_ext;
        logic          loop_found;
    } t_ring;

    class forward_book;
        cfr_pkg::t_rule rules[RULE_SLOTS];
        int             n_rules;
        t_ring          expected_rings[$];
        int             faults;

        function new();
            n_rules = 0;
            faults  = 0;
        endfunction

        function t_ring resolve_call(logic [FW-1:0] dialed, logic [FW-1:0] at);
            logic [FW-1:0] path[$];
            logic [FW-1:0] cur;
            t_ring ring;
            int hit;
            bit walking;
            bit seen;
            cur = dialed;
            path = {path, dialed};
            ring.loop_found = 1'b0;
            walking = 1'b1;
            while (walking) begin
                hit = -1;
                for (int k = 0; k < n_rules && hit < 0; k++) begin
                    if (rules[k].src == cur && at >= rules[k].start &&
                        int'(at) <= int'(rules[k].start) + int'(rules[k].len)) begin
                        hit = k;
                    end
                end
                if (hit < 0) begin
                    walking = 1'b0;
                end else begin
                    cur  = rules[hit].to;
                    seen = 1'b0;
                    foreach (path[j]) begin
                        if (path[j] == cur) seen = 1'b1;
                    end
                    if (seen || path.size() >= RULE_SLOTS + 1) begin
                        ring.loop_found = 1'b1;
                        walking = 1'b0;
                    end else begin
                        path = {path, cur};
                    end
                end
            end
            ring.final_ext = ring.loop_found ? cfr_pkg::LOOP_EXT : cur;
            return ring;
        endfunction

        function void note_item(logic [CW-1:0] cmd, logic [FW-1:0] ext,
                                logic [FW-1:0] when, logic [FW-1:0] span,
                                logic [FW-1:0] dest);
            case (cmd)
                cfr_pkg::CMD_CLEAR: begin
                    n_rules = 0;
                end
                cfr_pkg::CMD_ADD: begin
                    if (n_rules < RULE_SLOTS) begin
                        rules[n_rules] = '{src: ext, start: when, len: span, to: dest};
                        n_rules++;
                    end
                end
                cfr_pkg::CMD_RESOLVE: begin
                    expected_rings = {expected_rings, resolve_call(ext, when)};
                end
                default: ;
            endcase
        endfunction

        function void check_ring(t_ring got);
            t_ring want;
            if (expected_rings.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("unexpected result: final_ext %0d loop_found %0b",
                             got.final_ext, got.loop_found);
                return;
            end
            want = expected_rings.pop_front();
            if (got.final_ext !== want.final_ext) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("final_ext: expected %0d, got %0d", want.final_ext, got.final_ext);
            end
            if (got.loop_found !== want.loop_found) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("loop_found: expected %0b, got %0b", want.loop_found,
                             got.loop_found);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cfr_in_if  in_ch ();
    cfr_out_if out_ch ();

    call_forward_resolver_unit #(
        .MAX_RULES(RULE_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    forward_book book;
    int send_calm = 0;
    int sink_calm = 0;
    int items_sent = 0;
    int cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [FW-1:0] rnd14();
        return FW'($urandom);
    endfunction

    function automatic logic [FW-1:0] pick_time();
        if ($urandom_range(0, 9) == 0) return rnd14();
        return FW'($urandom_range(0, 40));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                book.note_item(in_ch.cmd, in_ch.ext, in_ch.when, in_ch.span, in_ch.dest);
            if (out_ch.valid && out_ch.ready)
                book.check_ring('{final_ext: out_ch.final_ext, loop_found: out_ch.loop_found});
        end
    end

    task automatic send_item(logic [CW-1:0] cmd, logic [FW-1:0] ext,
                             logic [FW-1:0] when, logic [FW-1:0] span,
                             logic [FW-1:0] dest);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.ext   <= ext;
        in_ch.when  <= when;
        in_ch.span  <= span;
        in_ch.dest  <= dest;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (book.expected_rings.size() != 0);
    endtask

    task automatic chain_burst();
        logic [FW-1:0] base;
        int n;
        base = FW'($urandom_range(0, 16383 - 8));
        if ($urandom_range(0, 3) != 0)
            send_item(cfr_pkg::CMD_CLEAR, rnd14(), rnd14(), rnd14(), rnd14());
        n = $urandom_range(1, 10);
        repeat (n)
            send_item(cfr_pkg::CMD_ADD, base + FW'($urandom_range(0, 5)), pick_time(),
                      pick_time(), base + FW'($urandom_range(0, 6)));
        n = $urandom_range(1, 5);
        repeat (n)
            send_item(cfr_pkg::CMD_RESOLVE, base + FW'($urandom_range(0, 6)),
                      ($urandom_range(0, 9) == 0) ? rnd14() : FW'($urandom_range(0, 90)),
                      rnd14(), rnd14());
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) send_item(CW'($urandom), rnd14(), rnd14(), rnd14(), rnd14());
    endtask

    // full table walked end to end: one chain of every rule, added back to front
    task automatic fill_table();
        logic [FW-1:0] base;
        logic [FW-1:0] at;
        logic [FW-1:0] lo;
        base = FW'($urandom_range(0, 16383 - 70));
        at   = rnd14();
        send_item(cfr_pkg::CMD_CLEAR, rnd14(), rnd14(), rnd14(), rnd14());
        for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
            lo = FW'($urandom_range(0, at));
            send_item(cfr_pkg::CMD_ADD, base + FW'(i), lo, at - lo, base + FW'(i + 1));
        end
        send_item(cfr_pkg::CMD_ADD, base + FW'(RULE_SLOTS), '0, EXT_TOP, base);
        send_item(cfr_pkg::CMD_RESOLVE, base, at, rnd14(), rnd14());
        send_item(cfr_pkg::CMD_RESOLVE, base + FW'(RULE_SLOTS), at, rnd14(), rnd14());
        send_item(cfr_pkg::CMD_RESOLVE, base + FW'($urandom_range(0, 63)), at, rnd14(),
                  rnd14());
        send_item(cfr_pkg::CMD_RESOLVE, base, rnd14(), rnd14(), rnd14());
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            int stall;
            stall = draw_wait(sink_calm);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int seq;
        int pick;
        book = new();
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd   <= cfr_pkg::CMD_CLEAR;
        in_ch.ext   <= '0;
        in_ch.when  <= '0;
        in_ch.span  <= '0;
        in_ch.dest  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(cfr_pkg::CMD_RESOLVE, '0, '0, '0, '0);
        send_item(cfr_pkg::CMD_ADD, 14'd100, 14'd10, 14'd5, 14'd200);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd100, 14'd10, '0, '0);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd100, 14'd15, '0, '0);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd100, 14'd16, '0, '0);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd100, 14'd9, '0, '0);
        // back to the dialed extension
        send_item(cfr_pkg::CMD_ADD, 14'd200, '0, EXT_TOP, 14'd100);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd100, 14'd12, '0, '0);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd200, 14'd12, '0, '0);
        // earlier rule wins
        send_item(cfr_pkg::CMD_ADD, 14'd300, '0, 14'd100, 14'd301);
        send_item(cfr_pkg::CMD_ADD, 14'd300, '0, 14'd100, 14'd302);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd300, 14'd50, '0, '0);
        send_item(CMD_SPARE, EXT_TOP, EXT_TOP, EXT_TOP, EXT_TOP);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd300, 14'd100, '0, '0);
        send_item(cfr_pkg::CMD_ADD, EXT_TOP, EXT_TOP, EXT_TOP, '0);
        send_item(cfr_pkg::CMD_ADD, '0, '0, '0, EXT_TOP);
        send_item(cfr_pkg::CMD_RESOLVE, EXT_TOP, EXT_TOP, EXT_TOP, EXT_TOP);
        send_item(cfr_pkg::CMD_RESOLVE, '0, '0, '0, '0);
        send_item(cfr_pkg::CMD_ADD, 14'd500, 14'd5, '0, 14'd500);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd500, 14'd5, '0, '0);
        send_item(cfr_pkg::CMD_CLEAR, EXT_TOP, EXT_TOP, EXT_TOP, EXT_TOP);
        send_item(cfr_pkg::CMD_RESOLVE, 14'd100, 14'd10, '0, '0);
        drain();

        seq = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (seq == 2)
                fill_table();
            else if (pick < 7)
                chain_burst();
            else
                noise_burst();
            if (seq == 4 || $urandom_range(0, 5) == 0)
                drain();
            seq++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.faults == 0 && book.expected_rings.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/cfr_pkg.sv
rtl/core/cfr_in_if.sv
rtl/core/cfr_out_if.sv
rtl/core/cfr_ctrl.sv
rtl/core/cfr_dp.sv
rtl/core/call_forward_resolver_unit.sv
sim/tb_top.sv
